[rtl/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants of the RGB bilinear sampler
// Field widths, store geometry, queue entry layout and register indexes.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned COORD_W   = 9;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned PIX_W     = NUM_CH * CH_W;
  localparam int unsigned SIZE_W    = 10;

  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;

  // weights run 0 .. 2^(2*FRAC_BITS) inclusive
  localparam int unsigned OMF_W  = FRAC_BITS + 1;
  localparam int unsigned WT_W   = 2 * FRAC_BITS + 1;
  localparam int unsigned PROD_W = WT_W + CH_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // four banks split on row and column parity
  localparam int unsigned NUM_BANKS = 4;
  localparam int unsigned BANK_AW   = 2 * (COORD_W - 1);
  localparam int unsigned BANK_DEPTH = 1 << BANK_AW;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                              op;
    logic [COORD_W-1:0]               row0;
    logic [COORD_W-1:0]               row1;
    logic [COORD_W-1:0]               col0;
    logic [COORD_W-1:0]               col1;
    logic [PIX_W-1:0]                 pixel;
    logic [NUM_BANKS-1:0][WT_W-1:0]   wt;
  } q_entry_t;

endpackage

[rtl/rgb_bilinear_sampler.sv]
// ----------------------------------------------------------------------------
// rgb_bilinear_sampler: bilinear RGB resampler over an internal image store
//
//   channel  handshake                  payload
//   -------  -------------------------  --------------------------------------
//   cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in_valid_i / in_stall_o    func, row, col, frac_row/col, pixel_*
//   out      out_valid_o / out_stall_i  out_red, out_green, out_blue
//
// One item per cycle while in_stall_o is low; a sample's result passes through the queue,
// the bank read, the product stage and the sum into the output register.
// All four neighbors come from four row/column parity banks in a single read.
// in_stall_o rises when the 4-entry queue fills; out_stall_i freezes the back
// pipeline only. Reset clears control state; the pixel store is not cleared.
// ----------------------------------------------------------------------------
module rgb_bilinear_sampler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rbs_pkg::SIZE_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [rbs_pkg::COORD_W-1:0]    row_i,
  input  logic [rbs_pkg::COORD_W-1:0]    col_i,
  input  logic [rbs_pkg::FRAC_W-1:0]     frac_row_i,
  input  logic [rbs_pkg::FRAC_W-1:0]     frac_col_i,
  input  logic [rbs_pkg::CH_W-1:0]       pixel_red_i,
  input  logic [rbs_pkg::CH_W-1:0]       pixel_green_i,
  input  logic [rbs_pkg::CH_W-1:0]       pixel_blue_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rbs_pkg::CH_W-1:0]       out_red_o,
  output logic [rbs_pkg::CH_W-1:0]       out_green_o,
  output logic [rbs_pkg::CH_W-1:0]       out_blue_o
);
  import rbs_pkg::*;

  logic     push, pop, q_full, q_empty;
  q_entry_t push_entry, pop_entry;

  rbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .frac_row_i    (frac_row_i),
    .frac_col_i    (frac_col_i),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  rbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .entry_o (pop_entry)
  );

  rbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

endmodule

[rtl/rbs_front.sv]
// ----------------------------------------------------------------------------
// rbs_front: item intake and classification
// Holds the size registers, clamps coordinates and neighbors to the image,
// drops writes outside the image and forms the four bilinear weights.
// ----------------------------------------------------------------------------
module rbs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rbs_pkg::SIZE_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [rbs_pkg::COORD_W-1:0]    row_i,
  input  logic [rbs_pkg::COORD_W-1:0]    col_i,
  input  logic [rbs_pkg::FRAC_W-1:0]     frac_row_i,
  input  logic [rbs_pkg::FRAC_W-1:0]     frac_col_i,
  input  logic [rbs_pkg::CH_W-1:0]       pixel_red_i,
  input  logic [rbs_pkg::CH_W-1:0]       pixel_green_i,
  input  logic [rbs_pkg::CH_W-1:0]       pixel_blue_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output rbs_pkg::q_entry_t              entry_o
);
  import rbs_pkg::*;

  logic [SIZE_W-1:0]    width_q, height_q;
  logic [SIZE_W-1:0]    w_eff, h_eff;
  logic [COORD_W-1:0]   last_col, last_row;
  logic [COORD_W-1:0]   r0, c0, r1, c1;
  logic                 in_image;
  logic [FRAC_BITS-1:0] fr, fc;
  logic [OMF_W-1:0]     omr, omc, frx, fcx;
  logic [2*OMF_W-1:0]   p0, p1, p2, p3;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(MAX_WIDTH);
      height_q <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    priority if (width_q == '0) begin
      w_eff = SIZE_W'(1);
    end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    priority if (height_q == '0) begin
      h_eff = SIZE_W'(1);
    end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign last_col = COORD_W'(w_eff - SIZE_W'(1));
  assign last_row = COORD_W'(h_eff - SIZE_W'(1));

  assign in_image = (SIZE_W'(row_i) < h_eff) && (SIZE_W'(col_i) < w_eff);

  assign r0 = (SIZE_W'(row_i) < h_eff) ? row_i : last_row;
  assign c0 = (SIZE_W'(col_i) < w_eff) ? col_i : last_col;
  assign r1 = (r0 == last_row) ? r0 : r0 + COORD_W'(1);
  assign c1 = (c0 == last_col) ? c0 : c0 + COORD_W'(1);

  assign fr  = frac_row_i[FRAC_BITS-1:0];
  assign fc  = frac_col_i[FRAC_BITS-1:0];
  assign frx = OMF_W'(fr);
  assign fcx = OMF_W'(fc);
  assign omr = OMF_W'(1 << FRAC_BITS) - frx;
  assign omc = OMF_W'(1 << FRAC_BITS) - fcx;
  assign p0  = omr * omc;
  assign p1  = omr * fcx;
  assign p2  = frx * omc;
  assign p3  = frx * fcx;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && (func_i || in_image);

  always_comb begin
    entry_o.op    = func_i ? OP_SAMPLE : OP_WRITE;
    entry_o.row0  = func_i ? r0 : row_i;
    entry_o.row1  = r1;
    entry_o.col0  = func_i ? c0 : col_i;
    entry_o.col1  = c1;
    entry_o.pixel = {pixel_blue_i, pixel_green_i, pixel_red_i};
    entry_o.wt[0] = p0[WT_W-1:0];
    entry_o.wt[1] = p1[WT_W-1:0];
    entry_o.wt[2] = p2[WT_W-1:0];
    entry_o.wt[3] = p3[WT_W-1:0];
  end

endmodule

[rtl/rbs_queue.sv]
// ----------------------------------------------------------------------------
// rbs_queue: short queue between front and back
// Four-entry register queue with a fill count; full is taken from the
// registered count.
// ----------------------------------------------------------------------------
module rbs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rbs_pkg::q_entry_t entry_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output rbs_pkg::q_entry_t entry_o
);
  import rbs_pkg::*;

  q_entry_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/rbs_back.sv]
// ----------------------------------------------------------------------------
// rbs_back: pixel store and blend pipeline
// Four parity banks give all neighbors in one read; weighted products are
// registered, then summed and truncated into the output register.
// ----------------------------------------------------------------------------
module rbs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  rbs_pkg::q_entry_t          entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rbs_pkg::CH_W-1:0]   out_red_o,
  output logic [rbs_pkg::CH_W-1:0]   out_green_o,
  output logic [rbs_pkg::CH_W-1:0]   out_blue_o
);
  import rbs_pkg::*;

  logic                                   advance;
  logic                                   s1_valid_q, s2_valid_q, out_valid_q;
  logic                                   r0p_q, r1p_q, c0p_q, c1p_q;
  logic [NUM_BANKS-1:0][WT_W-1:0]         s1_wt_q;
  logic [PIX_W-1:0]                       rd_q [NUM_BANKS];
  logic [NUM_BANKS-1:0][PIX_W-1:0]        px;
  logic [NUM_CH-1:0][NUM_BANKS-1:0][PROD_W-1:0] prod_q;
  logic [NUM_CH-1:0][SUM_W-1:0]           sum;
  logic [NUM_CH-1:0][CH_W-1:0]            res_q;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !q_empty_i;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [PIX_W-1:0]   mem [BANK_DEPTH];
    logic [COORD_W-1:0] row_sel, col_sel;
    logic [BANK_AW-1:0] addr;
    logic               we;

    assign row_sel = (entry_i.row0[0] == b[1]) ? entry_i.row0 : entry_i.row1;
    assign col_sel = (entry_i.col0[0] == b[0]) ? entry_i.col0 : entry_i.col1;
    assign addr    = {row_sel[COORD_W-1:1], col_sel[COORD_W-1:1]};
    assign we      = pop_o && (entry_i.op == OP_WRITE) &&
                     (entry_i.row0[0] == b[1]) && (entry_i.col0[0] == b[0]);

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[addr] <= entry_i.pixel;
      end
      if (advance) begin
        rd_q[b] <= mem[addr];
      end
    end
  end

  assign px[0] = rd_q[{r0p_q, c0p_q}];
  assign px[1] = rd_q[{r0p_q, c1p_q}];
  assign px[2] = rd_q[{r1p_q, c0p_q}];
  assign px[3] = rd_q[{r1p_q, c1p_q}];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum[ch] = SUM_W'(prod_q[ch][0]) + SUM_W'(prod_q[ch][1]) +
                SUM_W'(prod_q[ch][2]) + SUM_W'(prod_q[ch][3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_o && (entry_i.op == OP_SAMPLE);
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r0p_q   <= entry_i.row0[0];
      r1p_q   <= entry_i.row1[0];
      c0p_q   <= entry_i.col0[0];
      c1p_q   <= entry_i.col1[0];
      s1_wt_q <= entry_i.wt;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int k = 0; k < NUM_BANKS; k++) begin
          prod_q[ch][k] <= s1_wt_q[k] * PROD_W'(px[k][ch*CH_W +: CH_W]);
        end
        res_q[ch] <= sum[ch][2*FRAC_BITS +: CH_W];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = res_q[0];
  assign out_green_o = res_q[1];
  assign out_blue_o  = res_q[2];

endmodule

[tb/sv/rgb_bilinear_sampler_tb.sv]
// ----------------------------------------------------------------------------
// rgb_bilinear_sampler_tb: self-checking bench for the RGB bilinear sampler
// Fills parts of the pixel store, samples with Q0.8 fractions under several
// image sizes, and compares every output transfer against a local blend of
// the four clamped neighbors. Samples only touch pixels already written.
// ----------------------------------------------------------------------------
module rgb_bilinear_sampler_tb;
  import rbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_PHASES   = 7;

  typedef struct packed {
    op_e               func;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [FRAC_W-1:0]  frac_row;
    logic [FRAC_W-1:0]  frac_col;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
  } pixel_req_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  class resample_scoreboard;
    logic [PIX_W-1:0]  image [int unsigned];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    rgb_t              blend_q [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       stored;
    int unsigned       ignored;

    function new();
      width_reg  = SIZE_W'(MAX_WIDTH);
      height_reg = SIZE_W'(MAX_HEIGHT);
      errors     = 0;
      checked    = 0;
      stored     = 0;
      ignored    = 0;
    endfunction

    function void set_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = data;
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = data;
      end
    endfunction

    function int unsigned span(logic [SIZE_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function int unsigned cols_in_use();
      return span(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned rows_in_use();
      return span(height_reg, MAX_HEIGHT);
    endfunction

    function bit in_image(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      return (row < rows_in_use()) && (col < cols_in_use());
    endfunction

    // k[1] selects the lower row, k[0] the right column
    function void corner(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col, int unsigned k,
                         output int unsigned r, output int unsigned c);
      int unsigned h, w, r0, c0;
      h  = rows_in_use();
      w  = cols_in_use();
      r0 = (row < h) ? row : h - 1;
      c0 = (col < w) ? col : w - 1;
      r  = r0;
      c  = c0;
      if (k[1]) r = (r0 + 1 < h) ? r0 + 1 : h - 1;
      if (k[0]) c = (c0 + 1 < w) ? c0 + 1 : w - 1;
    endfunction

    function bit find_unwritten(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                output int unsigned r, output int unsigned c);
      for (int unsigned k = 0; k < NUM_BANKS; k++) begin
        corner(row, col, k, r, c);
        if (!image.exists(r * MAX_WIDTH + c)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function rgb_t blend(pixel_req_t it);
      int unsigned      one;
      int unsigned      fr, fc, acc, r, c;
      int unsigned      wt [NUM_BANKS];
      logic [PIX_W-1:0] px;
      logic [CH_W-1:0]  chan [NUM_CH];
      rgb_t             res;
      one   = 1 << FRAC_BITS;
      fr    = it.frac_row & (one - 1);
      fc    = it.frac_col & (one - 1);
      wt[0] = (one - fr) * (one - fc);
      wt[1] = (one - fr) * fc;
      wt[2] = fr * (one - fc);
      wt[3] = fr * fc;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        acc = 0;
        for (int unsigned k = 0; k < NUM_BANKS; k++) begin
          corner(it.row, it.col, k, r, c);
          px  = image[r * MAX_WIDTH + c];
          acc += wt[k] * px[ch*CH_W +: CH_W];
        end
        chan[ch] = CH_W'(acc >> (2 * FRAC_BITS));
      end
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      return res;
    endfunction

    function void note_input(pixel_req_t it);
      if (it.func == OP_WRITE) begin
        if (in_image(it.row, it.col)) begin
          image[it.row * MAX_WIDTH + it.col] = {it.blue, it.green, it.red};
          stored++;
        end else begin
          ignored++;
        end
      end else begin
        blend_q.push_back(blend(it));
      end
    endfunction

    function void check_result(rgb_t got);
      rgb_t want;
      if (blend_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected output transfer: red %0d green %0d blue %0d",
                   got.red, got.green, got.blue);
        return;
      end
      want = blend_q.pop_front();
      checked++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: red exp %0d got %0d, green exp %0d got %0d, blue exp %0d got %0d",
                   want.red, got.red, want.green, got.green, want.blue, got.blue);
      end
    endfunction

    function int unsigned pending();
      return blend_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SIZE_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 func_i;
  logic [COORD_W-1:0]   row_i;
  logic [COORD_W-1:0]   col_i;
  logic [FRAC_W-1:0]    frac_row_i;
  logic [FRAC_W-1:0]    frac_col_i;
  logic [CH_W-1:0]      pixel_red_i;
  logic [CH_W-1:0]      pixel_green_i;
  logic [CH_W-1:0]      pixel_blue_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CH_W-1:0]      out_red_o;
  logic [CH_W-1:0]      out_green_o;
  logic [CH_W-1:0]      out_blue_o;

  resample_scoreboard sb;
  int unsigned        cycle_count = 0;
  int unsigned        out_cycles  = 0;
  int unsigned        stall_left  = 0;
  bit                 quiet_out   = 1'b0;
  bit                 quiet_in    = 1'b0;
  bit                 stall_next;
  int unsigned        cfg_writes  = 0;
  int unsigned        row_zone, col_zone, mid_row, mid_col;

  rgb_bilinear_sampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .frac_row_i    (frac_row_i),
    .frac_col_i    (frac_col_i),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rgb_bilinear_sampler_tb NOT OK");
      $finish;
    end
  end

  // output side: check transfers, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(rgb_t'({out_red_o, out_green_o, out_blue_o}));
    if (out_cycles % 150 == 0) quiet_out = ($urandom_range(0, 3) == 0);
    out_cycles++;
    if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if (quiet_out) begin
      stall_next = 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  stall_next = 1'b0;
        [70:95]: begin
          stall_next = 1'b1;
          stall_left = $urandom_range(0, 2);
        end
        default: begin
          stall_next = 1'b1;
          stall_left = $urandom_range(10, 40);
        end
      endcase
    end
    out_stall_i <= stall_next;
  end

  function automatic int unsigned pick_gap();
    if (quiet_in) return 0;
    case ($urandom_range(0, 99)) inside
      [0:54]:  return 0;
      [55:84]: return $urandom_range(1, 2);
      [85:96]: return $urandom_range(3, 8);
      default: return $urandom_range(15, 50);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pick_frac();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return FRAC_W'($urandom);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int unsigned span, int unsigned zone,
                                                    int unsigned mid);
    if (span < 512 && $urandom_range(0, 19) == 0) return COORD_W'($urandom_range(span, 511));
    if (span <= 8) return COORD_W'($urandom_range(0, span - 1));
    case (zone)
      0:       return COORD_W'($urandom_range(0, 3));
      1:       return COORD_W'($urandom_range(span - 4, span - 1));
      default: return COORD_W'(mid + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic push_item(pixel_req_t it);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    func_i        <= it.func;
    row_i         <= it.row;
    col_i         <= it.col;
    frac_row_i    <= it.frac_row;
    frac_col_i    <= it.frac_col;
    pixel_red_i   <= it.red;
    pixel_green_i <= it.green;
    pixel_blue_i  <= it.blue;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic put_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                           logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                           logic [CH_W-1:0] blue);
    pixel_req_t it;
    it.func     = OP_WRITE;
    it.row      = row;
    it.col      = col;
    it.frac_row = FRAC_W'($urandom);
    it.frac_col = FRAC_W'($urandom);
    it.red      = red;
    it.green    = green;
    it.blue     = blue;
    push_item(it);
  endtask

  task automatic sample_at(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                           logic [FRAC_W-1:0] fr, logic [FRAC_W-1:0] fc);
    pixel_req_t it;
    it.func     = OP_SAMPLE;
    it.row      = row;
    it.col      = col;
    it.frac_row = fr;
    it.frac_col = fc;
    it.red      = CH_W'($urandom);
    it.green    = CH_W'($urandom);
    it.blue     = CH_W'($urandom);
    push_item(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_size(idx, data);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // mostly samples; a sample whose neighbors are not all stored yet becomes
  // a write of the first missing neighbor, so the windows fill as it runs
  task automatic random_phase(int unsigned n);
    int unsigned        done, iter, h, w, r, c;
    logic [COORD_W-1:0] row, col;
    done = 0;
    iter = 0;
    h    = sb.rows_in_use();
    w    = sb.cols_in_use();
    while (done < n) begin
      if (iter % 24 == 0) begin
        row_zone = $urandom_range(0, 2);
        col_zone = $urandom_range(0, 2);
        mid_row  = (h > 16) ? $urandom_range(4, h - 8) : 0;
        mid_col  = (w > 16) ? $urandom_range(4, w - 8) : 0;
        quiet_in = ($urandom_range(0, 4) == 0);
      end
      iter++;
      case ($urandom_range(0, 99)) inside
        [0:5]: begin
          row = COORD_W'($urandom);
          col = COORD_W'($urandom);
          put_pixel(row, col, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
          if (sb.in_image(row, col)) done++;
        end
        [6:21]: begin
          row = pick_coord(h, row_zone, mid_row);
          col = pick_coord(w, col_zone, mid_col);
          put_pixel(row, col, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
          if (sb.in_image(row, col)) done++;
        end
        default: begin
          row = pick_coord(h, row_zone, mid_row);
          col = pick_coord(w, col_zone, mid_col);
          if (sb.find_unwritten(row, col, r, c))
            put_pixel(COORD_W'(r), COORD_W'(c), CH_W'($urandom), CH_W'($urandom),
                      CH_W'($urandom));
          else
            sample_at(row, col, pick_frac(), pick_frac());
          done++;
        end
      endcase
    end
    quiet_in = 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0] widths  [NUM_PHASES] = '{0, 1, 1023, 513, 17, 512, 2};
    logic [SIZE_W-1:0] heights [NUM_PHASES] = '{0, 512, 2, 1023, 9, 1, 2};
    int unsigned       counts  [NUM_PHASES] = '{25, 40, 50, 110, 70, 35, 30};
    sb            = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_IMAGE_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    func_i        = OP_WRITE;
    row_i         = '0;
    col_i         = '0;
    frac_row_i    = '0;
    frac_col_i    = '0;
    pixel_red_i   = '0;
    pixel_green_i = '0;
    pixel_blue_i  = '0;
    out_stall_i   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-size image: corners, fraction extremes, edge clamping
    put_pixel(0, 0, 8'hff, 8'hff, 8'hff);
    put_pixel(0, 1, 8'h00, 8'h00, 8'h00);
    put_pixel(1, 0, 8'ha5, 8'h5a, 8'hc3);
    put_pixel(1, 1, 8'h01, 8'h80, 8'h7f);
    put_pixel(511, 511, 8'hff, 8'hff, 8'hff);
    put_pixel(511, 510, 8'h00, 8'h00, 8'h00);
    put_pixel(510, 511, 8'h12, 8'h34, 8'h56);
    put_pixel(510, 510, 8'h80, 8'h80, 8'h80);
    sample_at(0, 0, 8'd0, 8'd0);
    sample_at(0, 0, 8'd255, 8'd255);
    sample_at(0, 0, 8'd128, 8'd0);
    sample_at(0, 0, 8'd0, 8'd255);
    sample_at(0, 0, 8'd255, 8'd0);
    sample_at(510, 510, 8'd255, 8'd255);
    sample_at(511, 511, 8'd77, 8'd200);
    sample_at(511, 510, 8'd255, 8'd128);
    sample_at(510, 511, 8'd128, 8'd255);

    // 5x3 image: writes outside are dropped, samples outside are clamped
    set_register(REG_IMAGE_WIDTH, 10'd5);
    set_register(REG_IMAGE_HEIGHT, 10'd3);
    put_pixel(2, 4, 8'h3c, 8'hc3, 8'h99);
    put_pixel(3, 0, 8'h11, 8'h22, 8'h33);
    put_pixel(0, 5, 8'h44, 8'h55, 8'h66);
    sample_at(2, 4, 8'd255, 8'd255);
    sample_at(400, 300, 8'd90, 8'd170);
    random_phase(60);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_register(REG_IMAGE_WIDTH, widths[p]);
      set_register(REG_IMAGE_HEIGHT, heights[p]);
      random_phase(counts[p]);
    end

    wait_idle();
    $display("checked %0d interpolated pixels across %0d register writes",
             sb.checked, cfg_writes);
    $display("stored %0d pixel writes, %0d writes fell outside the image",
             sb.stored, sb.ignored);
    if (sb.errors == 0) begin
      $display("rgb_bilinear_sampler_tb OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("rgb_bilinear_sampler_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rbs_pkg.sv
rtl/rbs_front.sv
rtl/rbs_queue.sv
rtl/rbs_back.sv
rtl/rgb_bilinear_sampler.sv
tb/sv/rgb_bilinear_sampler_tb.sv
